// ===== hdl/wip_pkg.sv =====
// ----------------------------------------------------------------------------
// wip_pkg: shared types and constants of the windowed integral pid
// Widths, register indices, reset values, payload structs, sequencer states
// and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package wip_pkg;

   localparam int MAX_WINDOW = 16;
   localparam int RING_AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LEN_W      = $clog2(MAX_WINDOW + 1);

   localparam int DATA_W = 32;
   localparam int GAIN_W = 24;
   localparam int STEP_W = 16;
   localparam int FRAC_W = 16;
   localparam int WLEN_W = 5;
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam int SUM_W  = DATA_W + RING_AW;
   localparam int PROD_W = GAIN_W + SUM_W;
   localparam int DIFF_W = DATA_W + 1;
   localparam int DIV_W  = DIFF_W + FRAC_W;
   localparam int MCNT_W = $clog2(GAIN_W);
   localparam int DCNT_W = $clog2(DIV_W);

   localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 24'sd163840;
   localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 24'sd0;
   localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 24'sd13107;
   localparam logic signed [DATA_W-1:0] OUT_MIN_RST    = -32'sd16384000;
   localparam logic signed [DATA_W-1:0] OUT_MAX_RST    = 32'sd16384000;
   localparam logic                     CLAMP_EN_RST   = 1'b1;
   localparam logic [WLEN_W-1:0]        WINDOW_LEN_RST = 5'd6;

   typedef enum logic [2:0] {
      REG_PROP_GAIN,
      REG_INTEG_GAIN,
      REG_DERIV_GAIN,
      REG_OUT_MIN,
      REG_OUT_MAX,
      REG_CLAMP_ENABLE,
      REG_WINDOW_LEN
   } reg_idx_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic signed [GAIN_W-1:0] deriv_gain;
      logic signed [DATA_W-1:0] out_min;
      logic signed [DATA_W-1:0] out_max;
      logic                     clamp_enable;
      logic [WLEN_W-1:0]        window_len;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] error_sample;
      logic [STEP_W-1:0]        step_time;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive;
      logic signed [DATA_W-1:0] prop_term;
      logic signed [DATA_W-1:0] integ_term;
      logic signed [DATA_W-1:0] deriv_term;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_WRITE,
      ST_SUM,
      ST_INTEG,
      ST_PROP,
      ST_DIV,
      ST_DERIV,
      ST_FINAL
   } state_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (x > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (x < lo) begin
         return 32'sh8000_0000;
      end
      return x[DATA_W-1:0];
   endfunction

endpackage

// ===== hdl/wip_csr.sv =====
// ----------------------------------------------------------------------------
// wip_csr: configuration registers
// APB-style register file holding gains, clamp bounds and window length.
// ----------------------------------------------------------------------------
module wip_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [wip_pkg::CSR_AW-1:0]  paddr,
   input  logic [wip_pkg::CSR_DW-1:0]  pwdata,
   output logic [wip_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output wip_pkg::cfg_type            cfg
);

   wip_pkg::cfg_type     cfg_ff;
   wip_pkg::cfg_type     cfg_in;
   wip_pkg::reg_idx_type reg_idx;
   logic                 wr_en;

   assign reg_idx = wip_pkg::reg_idx_type'(paddr[wip_pkg::CSR_AW-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            wip_pkg::REG_PROP_GAIN:    cfg_in.prop_gain    = pwdata[wip_pkg::GAIN_W-1:0];
            wip_pkg::REG_INTEG_GAIN:   cfg_in.integ_gain   = pwdata[wip_pkg::GAIN_W-1:0];
            wip_pkg::REG_DERIV_GAIN:   cfg_in.deriv_gain   = pwdata[wip_pkg::GAIN_W-1:0];
            wip_pkg::REG_OUT_MIN:      cfg_in.out_min      = pwdata[wip_pkg::DATA_W-1:0];
            wip_pkg::REG_OUT_MAX:      cfg_in.out_max      = pwdata[wip_pkg::DATA_W-1:0];
            wip_pkg::REG_CLAMP_ENABLE: cfg_in.clamp_enable = pwdata[0];
            wip_pkg::REG_WINDOW_LEN:   cfg_in.window_len   = pwdata[wip_pkg::WLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         wip_pkg::REG_PROP_GAIN:    prdata = wip_pkg::CSR_DW'(cfg_ff.prop_gain);
         wip_pkg::REG_INTEG_GAIN:   prdata = wip_pkg::CSR_DW'(cfg_ff.integ_gain);
         wip_pkg::REG_DERIV_GAIN:   prdata = wip_pkg::CSR_DW'(cfg_ff.deriv_gain);
         wip_pkg::REG_OUT_MIN:      prdata = wip_pkg::CSR_DW'(cfg_ff.out_min);
         wip_pkg::REG_OUT_MAX:      prdata = wip_pkg::CSR_DW'(cfg_ff.out_max);
         wip_pkg::REG_CLAMP_ENABLE: prdata = wip_pkg::CSR_DW'(cfg_ff.clamp_enable);
         wip_pkg::REG_WINDOW_LEN:   prdata = wip_pkg::CSR_DW'(cfg_ff.window_len);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain    <= wip_pkg::PROP_GAIN_RST;
         cfg_ff.integ_gain   <= wip_pkg::INTEG_GAIN_RST;
         cfg_ff.deriv_gain   <= wip_pkg::DERIV_GAIN_RST;
         cfg_ff.out_min      <= wip_pkg::OUT_MIN_RST;
         cfg_ff.out_max      <= wip_pkg::OUT_MAX_RST;
         cfg_ff.clamp_enable <= wip_pkg::CLAMP_EN_RST;
         cfg_ff.window_len   <= wip_pkg::WINDOW_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/wip_mul.sv =====
// ----------------------------------------------------------------------------
// wip_mul: shared shift-add gain multiplier
// Signed Q8.16 gain times a signed operand, one gain bit per cycle; the
// product is floored by 16 fraction bits and saturated to 32 bits.
// ----------------------------------------------------------------------------
module wip_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [wip_pkg::GAIN_W-1:0]  gain,
   input  logic signed [wip_pkg::SUM_W-1:0]   opnd,
   output logic                               done,
   output logic signed [wip_pkg::DATA_W-1:0]  result
);

   logic signed [wip_pkg::PROD_W-1:0] acc_ff, acc_in;
   logic signed [wip_pkg::PROD_W-1:0] mcand_ff, mcand_in;
   logic [wip_pkg::GAIN_W-1:0]        mplier_ff, mplier_in;
   logic [wip_pkg::MCNT_W-1:0]        cnt_ff, cnt_in;
   logic                              run_ff, run_in;
   logic                              done_ff, done_in;
   logic                              last_bit;

   assign last_bit = (cnt_ff == wip_pkg::MCNT_W'(wip_pkg::GAIN_W - 1));
   assign done     = done_ff;
   assign result   = wip_pkg::sat32(64'(acc_ff >>> wip_pkg::FRAC_W));

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = wip_pkg::PROD_W'(opnd);
         mplier_in = gain;
         cnt_in    = '0;
         run_in    = 1'b1;
      end else if (run_ff) begin
         // top gain bit carries negative weight
         if (mplier_ff[0]) begin
            acc_in = last_bit ? acc_ff - mcand_ff : acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (last_bit) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

endmodule

// ===== hdl/wip_div.sv =====
// ----------------------------------------------------------------------------
// wip_div: serial error-rate divider
// Restoring division of (error change << 16) by the time step, one quotient
// bit per cycle, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module wip_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [wip_pkg::DIFF_W-1:0]  diff,
   input  logic [wip_pkg::STEP_W-1:0]         divisor,
   output logic                               done,
   output logic signed [wip_pkg::DATA_W-1:0]  rate
);

   logic [wip_pkg::DIV_W-1:0]  num_ff, num_in;
   logic [wip_pkg::STEP_W-1:0] rem_ff, rem_in;
   logic [wip_pkg::STEP_W-1:0] dvs_ff, dvs_in;
   logic                       neg_ff, neg_in;
   logic [wip_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [wip_pkg::STEP_W:0]   rem_sh;
   logic [wip_pkg::DIFF_W-1:0] mag;
   logic signed [63:0]         quo_s;

   assign rem_sh = {rem_ff, num_ff[wip_pkg::DIV_W-1]};
   assign mag    = diff[wip_pkg::DIFF_W-1] ? wip_pkg::DIFF_W'(-diff) : wip_pkg::DIFF_W'(diff);
   assign quo_s  = neg_ff ? -$signed(64'(num_ff)) : $signed(64'(num_ff));
   assign rate   = wip_pkg::sat32(quo_s);
   assign done   = done_ff;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = {mag, {wip_pkg::FRAC_W{1'b0}}};
         rem_in = '0;
         dvs_in = divisor;
         neg_in = diff[wip_pkg::DIFF_W-1];
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = wip_pkg::STEP_W'(rem_sh - {1'b0, dvs_ff});
            num_in = {num_ff[wip_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[wip_pkg::STEP_W-1:0];
            num_in = {num_ff[wip_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == wip_pkg::DCNT_W'(wip_pkg::DIV_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

endmodule

// ===== hdl/windowed_integral_pid.sv =====
// ----------------------------------------------------------------------------
// windowed_integral_pid: pid controller with sliding-window integral
// Sequencer around a shared gain multiplier and a serial divider; the ring
// of error * step samples is summed one entry per cycle.
//
//   channel   ports                     direction  carries
//   req       req_valid/stall/data      in         error_sample, step_time
//   rsp       rsp_valid/stall/data      out        drive and the three terms
//   csr       psel..pready              in/out     gains, bounds, window
//
// A transaction runs from one acceptance to the next through the ring index
// reduction, the ring write, one summing step per window entry, the integral
// and proportional gain multiplies, the rate division, the derivative multiply,
// the output load and the idle state; the division and the derivative multiply
// are skipped when the previous error or the step is zero. req_stall is high
// from acceptance until the result is in the output register, later while a
// previous result stalls. Synchronous reset clears the ring through valid bits,
// so no clearing pass is needed. A stalled result holds while the next
// transaction is accepted.
module windowed_integral_pid (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  wip_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output wip_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [wip_pkg::CSR_AW-1:0]  paddr,
   input  logic [wip_pkg::CSR_DW-1:0]  pwdata,
   output logic [wip_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);

   wip_pkg::cfg_type   cfg;
   wip_pkg::state_type state_ff, state_in;

   logic signed [wip_pkg::DATA_W-1:0]  err_ff, err_in;
   logic [wip_pkg::STEP_W-1:0]         dt_ff, dt_in;
   logic [wip_pkg::LEN_W-1:0]          len_ff, len_in;
   logic [wip_pkg::RING_AW-1:0]        pos_ff, pos_in;
   logic [wip_pkg::RING_AW-1:0]        ring_pos_ff, ring_pos_in;
   logic [wip_pkg::RING_AW-1:0]        idx_ff, idx_in;
   logic signed [wip_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic signed [wip_pkg::DATA_W-1:0]  last_err_ff, last_err_in;
   logic signed [wip_pkg::DATA_W-1:0]  prop_ff, prop_in;
   logic signed [wip_pkg::DATA_W-1:0]  integ_ff, integ_in;
   logic signed [wip_pkg::DATA_W-1:0]  deriv_ff, deriv_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   wip_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   logic signed [wip_pkg::DATA_W-1:0]  ring_ff [wip_pkg::MAX_WINDOW];
   logic [wip_pkg::MAX_WINDOW-1:0]     ring_vld_ff, ring_vld_in;
   logic                               ring_we;
   logic signed [wip_pkg::DATA_W-1:0]  ring_rd;
   logic signed [48:0]                 ring_prod;
   logic signed [wip_pkg::DATA_W-1:0]  ring_wdata;

   logic [wip_pkg::LEN_W-1:0]          win_len;
   logic                               deriv_on;
   logic signed [wip_pkg::DIFF_W-1:0]  err_diff;
   logic signed [wip_pkg::DATA_W+1:0]  total;
   logic signed [wip_pkg::DATA_W-1:0]  total_sat;
   logic signed [wip_pkg::DATA_W-1:0]  drive_val;
   logic                               out_free;

   logic                               mul_start, mul_done;
   logic signed [wip_pkg::GAIN_W-1:0]  mul_gain;
   logic signed [wip_pkg::SUM_W-1:0]   mul_opnd;
   logic signed [wip_pkg::DATA_W-1:0]  mul_res;
   logic                               div_start, div_done;
   logic signed [wip_pkg::DATA_W-1:0]  div_rate;

   wip_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wip_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .gain   (mul_gain),
      .opnd   (mul_opnd),
      .done   (mul_done),
      .result (mul_res)
   );

   wip_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .diff    (err_diff),
      .divisor (dt_ff),
      .done    (div_done),
      .rate    (div_rate)
   );

   // window length limited to one .. ring depth
   always_comb begin
      if (cfg.window_len == '0) begin
         win_len = wip_pkg::LEN_W'(1);
      end else if (int'(cfg.window_len) > wip_pkg::MAX_WINDOW) begin
         win_len = wip_pkg::LEN_W'(wip_pkg::MAX_WINDOW);
      end else begin
         win_len = wip_pkg::LEN_W'(cfg.window_len);
      end
   end

   assign ring_prod  = err_ff * $signed({1'b0, dt_ff});
   assign ring_wdata = ring_prod[wip_pkg::DATA_W+wip_pkg::FRAC_W-1:wip_pkg::FRAC_W];
   assign ring_rd    = ring_vld_ff[idx_ff] ? ring_ff[idx_ff] : '0;
   assign err_diff   = wip_pkg::DIFF_W'(err_ff) - wip_pkg::DIFF_W'(last_err_ff);
   assign deriv_on   = (last_err_ff != '0) && (dt_ff != '0);

   assign total     = (wip_pkg::DATA_W+2)'(prop_ff) + (wip_pkg::DATA_W+2)'(integ_ff)
                      + (wip_pkg::DATA_W+2)'(deriv_ff);
   assign total_sat = wip_pkg::sat32(64'(total));

   always_comb begin
      drive_val = total_sat;
      if (cfg.clamp_enable) begin
         if (total_sat < cfg.out_min) begin
            drive_val = cfg.out_min;
         end else if (total_sat > cfg.out_max) begin
            drive_val = cfg.out_max;
         end
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != wip_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      dt_in        = dt_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      ring_pos_in  = ring_pos_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      last_err_in  = last_err_ff;
      prop_in      = prop_ff;
      integ_in     = integ_ff;
      deriv_in     = deriv_ff;
      ring_vld_in  = ring_vld_ff;
      ring_we      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;
      mul_gain     = cfg.prop_gain;
      mul_opnd     = wip_pkg::SUM_W'(err_ff);
      div_start    = 1'b0;
      case (state_ff)
         wip_pkg::ST_IDLE: begin
            if (req_valid) begin
               err_in   = req_data.error_sample;
               dt_in    = req_data.step_time;
               len_in   = win_len;
               pos_in   = ring_pos_ff;
               state_in = wip_pkg::ST_MOD;
            end
         end
         wip_pkg::ST_MOD: begin
            // write position modulo window length by repeated subtraction
            if (wip_pkg::LEN_W'(pos_ff) >= len_ff) begin
               pos_in = wip_pkg::RING_AW'(wip_pkg::LEN_W'(pos_ff) - len_ff);
            end else begin
               state_in = wip_pkg::ST_WRITE;
            end
         end
         wip_pkg::ST_WRITE: begin
            ring_we             = 1'b1;
            ring_vld_in[pos_ff] = 1'b1;
            if (wip_pkg::LEN_W'(pos_ff) + 1'b1 == len_ff) begin
               ring_pos_in = '0;
            end else begin
               ring_pos_in = pos_ff + 1'b1;
            end
            idx_in   = '0;
            sum_in   = '0;
            state_in = wip_pkg::ST_SUM;
         end
         wip_pkg::ST_SUM: begin
            sum_in = sum_ff + wip_pkg::SUM_W'(ring_rd);
            idx_in = idx_ff + 1'b1;
            if (wip_pkg::LEN_W'(idx_ff) + 1'b1 == len_ff) begin
               mul_start = 1'b1;
               mul_gain  = cfg.integ_gain;
               mul_opnd  = sum_in;
               state_in  = wip_pkg::ST_INTEG;
            end
         end
         wip_pkg::ST_INTEG: begin
            if (mul_done) begin
               integ_in  = mul_res;
               mul_start = 1'b1;
               mul_gain  = cfg.prop_gain;
               mul_opnd  = wip_pkg::SUM_W'(err_ff);
               state_in  = wip_pkg::ST_PROP;
            end
         end
         wip_pkg::ST_PROP: begin
            if (mul_done) begin
               prop_in = mul_res;
               if (deriv_on) begin
                  div_start = 1'b1;
                  state_in  = wip_pkg::ST_DIV;
               end else begin
                  deriv_in = '0;
                  state_in = wip_pkg::ST_FINAL;
               end
            end
         end
         wip_pkg::ST_DIV: begin
            if (div_done) begin
               mul_start = 1'b1;
               mul_gain  = cfg.deriv_gain;
               mul_opnd  = wip_pkg::SUM_W'(div_rate);
               state_in  = wip_pkg::ST_DERIV;
            end
         end
         wip_pkg::ST_DERIV: begin
            if (mul_done) begin
               deriv_in = mul_res;
               state_in = wip_pkg::ST_FINAL;
            end
         end
         wip_pkg::ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.drive      = drive_val;
               rsp_data_in.prop_term  = prop_ff;
               rsp_data_in.integ_term = integ_ff;
               rsp_data_in.deriv_term = deriv_ff;
               last_err_in            = err_ff;
               state_in               = wip_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wip_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wip_pkg::ST_IDLE;
         ring_pos_ff  <= '0;
         last_err_ff  <= '0;
         ring_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ring_pos_ff  <= ring_pos_in;
         last_err_ff  <= last_err_in;
         ring_vld_ff  <= ring_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_in_reg: begin
         err_ff      <= err_in;
         dt_ff       <= dt_in;
         len_ff      <= len_in;
         pos_ff      <= pos_in;
         idx_ff      <= idx_in;
         sum_ff      <= sum_in;
         prop_ff     <= prop_in;
         integ_ff    <= integ_in;
         deriv_ff    <= deriv_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_ff[pos_ff] <= ring_wdata;
      end
   end

   a_write_pos_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wip_pkg::ST_WRITE) |-> (wip_pkg::LEN_W'(pos_ff) < len_ff))
      else $error("ring write position outside window");

   a_sum_idx_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wip_pkg::ST_SUM) |-> (wip_pkg::LEN_W'(idx_ff) < len_ff))
      else $error("ring sum index outside window");

   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == wip_pkg::ST_INTEG || state_ff == wip_pkg::ST_PROP ||
                    state_ff == wip_pkg::ST_DERIV))
      else $error("multiplier finished outside a multiply phase");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == wip_pkg::ST_DIV))
      else $error("divider finished outside the divide phase");

   a_accept_starts_seq: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == wip_pkg::ST_MOD))
      else $error("accepted transaction did not start the sequence");

endmodule
